[src/assert_macros.svh]
// Assertion macros shared by the RTL of the coverage and depth test block.
// Include this file where concurrent checks are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[src/tcdt_pkg.sv]
// Package for the triangle coverage and depth test block.
// Holds cull mode codes, register indexes and shared widths; no dependencies.
`timescale 1ns / 1ps
package tcdt_pkg;
   localparam logic [1:0] CULL_NONE  = 2'd0;
   localparam logic [1:0] CULL_BACK  = 2'd1;
   localparam logic [1:0] CULL_FRONT = 2'd2;
   localparam logic REG_FACE_CULL    = 1'b0;
   localparam logic REG_FRONT_IS_CCW = 1'b1;
   localparam int COORD_W = 12;
   localparam int ZIN_W   = 24;
   localparam int AREA_W  = 27;
   localparam int NUM_W   = 52;
   localparam int QUO_W   = 26;
endpackage

[src/tcdt_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tcdt_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

[src/tcdt_div.sv]
// Restoring divider, one quotient bit per cycle, for the depth interpolation.
// Uses tcdt_pkg for widths.
`timescale 1ns / 1ps
module tcdt_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tcdt_pkg::NUM_W-1:0]   num,
   input  logic [tcdt_pkg::AREA_W-1:0]  den,
   output logic                         done,
   output logic [tcdt_pkg::QUO_W-1:0]   quo
);
   localparam int CNT_W = $clog2(tcdt_pkg::NUM_W + 1);
   logic [tcdt_pkg::NUM_W-1:0]  num_ff, num_in;
   logic [tcdt_pkg::AREA_W:0]   rem_ff, rem_in;
   logic [tcdt_pkg::AREA_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic                        busy_ff, busy_in, done_ff, done_in;
   logic [tcdt_pkg::AREA_W:0]   trial;

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[tcdt_pkg::AREA_W-1:0], num_ff[tcdt_pkg::NUM_W-1]};
      if (start) begin
         num_in  = num;
         den_in  = den;
         rem_in  = '0;
         cnt_in  = CNT_W'(tcdt_pkg::NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            num_in = {num_ff[tcdt_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[tcdt_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   // Quotient never exceeds the largest vertex depth, so its low bits suffice.
   assign quo  = num_ff[tcdt_pkg::QUO_W-1:0];
endmodule

[src/triangle_coverage_depth_test.sv]
// Top level of the triangle coverage and depth test block.
// Uses tcdt_pkg, tcdt_ram, tcdt_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage: each req_ word carries a triangle (three vertices with depth) and one
// pixel. The block answers every word with exactly one rsp_ word that holds the
// pixel position, the culled, covered and written flags and the fragment depth.
// The face culling select (index 0) and front_is_ccw (index 1) are written
// through csr_ while the block is idle.
// Sequence: for a culled, zero-area or uncovered pixel the accepted word passes
// through the areas, culling and coverage, then a decision step before rsp_tvalid
// rises. A covered pixel adds the depth products, their sum, a bit-serial
// divider of 52 steps plus its done flag, a memory read and the depth test
// before its result appears. One word is in flight at a time and a new word can
// be taken in the cycle after the result leaves.
// Reset: after reset is released a clearing pass writes all ones (farthest) to
// every depth entry, one entry a cycle, FB_WIDTH*FB_HEIGHT entries (65536 at the
// default size). req_tready stays low during the pass.
// Stall: the result sits in an output register until rsp_tready; the block does
// not accept a new word until its result has been taken.
module triangle_coverage_depth_test #(
   parameter int FB_WIDTH   = 256,
   parameter int FB_HEIGHT  = 256,
   parameter int DEPTH_BITS = 24
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // ax, ay, az, bx, by, bz, cx, cy, cz, pixel_x, pixel_y from bit 0 up
   input  logic [167:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_x, out_y, culled, covered, written, frag_depth from bit 0 up, zero fill
   output logic [47:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [1:0]   csr_wdata
);
   localparam int NPIX = FB_WIDTH * FB_HEIGHT;
   localparam int AW   = $clog2(NPIX);
   localparam int CW   = tcdt_pkg::COORD_W;
   localparam int ZW   = tcdt_pkg::ZIN_W;
   localparam int SW   = tcdt_pkg::AREA_W;
   localparam logic [DEPTH_BITS-1:0] DMAX = '1;

   localparam logic [3:0] ST_CLEAR = 4'd0;
   localparam logic [3:0] ST_IDLE  = 4'd1;
   localparam logic [3:0] ST_AREA  = 4'd2;
   localparam logic [3:0] ST_MUL   = 4'd3;
   localparam logic [3:0] ST_SUM   = 4'd4;
   localparam logic [3:0] ST_DIV   = 4'd5;
   localparam logic [3:0] ST_READ  = 4'd6;
   localparam logic [3:0] ST_TEST  = 4'd7;
   localparam logic [3:0] ST_OUT   = 4'd8;
   localparam logic [3:0] ST_PROD  = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [1:0] face_cull_ff;
   logic       front_ccw_ff;
   logic [AW-1:0] clr_ff, clr_in;

   // Captured item fields.
   logic signed [CW-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic [ZW-1:0] az_ff, bz_ff, cz_ff;
   logic [7:0] px_ff, py_ff;

   // Areas and products.
   logic signed [SW-1:0] t_ff, s0_ff, s1_ff, s2_ff;
   logic [SW-1:0] m0_ff, m1_ff, m2_ff, mt_ff;
   logic [tcdt_pkg::NUM_W-1:0] p0_ff, p1_ff, p2_ff;
   logic culled_ff, covered_ff, written_ff, pass_ok;
   logic [DEPTH_BITS-1:0] depth_ff;
   logic [AW-1:0] idx_ff;

   logic div_start, div_done;
   logic [tcdt_pkg::QUO_W-1:0] quo;
   logic ram_we;
   logic [AW-1:0] ram_waddr;
   logic [DEPTH_BITS-1:0] ram_wdata, ram_rdata;
   logic accept, in_fb;

   function automatic logic signed [SW-1:0] area2(
      input logic signed [SW-1:0] x0, input logic signed [SW-1:0] y0,
      input logic signed [SW-1:0] x1, input logic signed [SW-1:0] y1,
      input logic signed [SW-1:0] x2, input logic signed [SW-1:0] y2);
      area2 = (y1 - y0) * (x1 + x0) + (y2 - y1) * (x2 + x1) + (y0 - y2) * (x0 + x2);
   endfunction

   function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
      mag = v[SW-1] ? SW'(-v) : SW'(v);
   endfunction

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_OUT);
   assign in_fb      = (32'(px_ff) < 32'(FB_WIDTH)) && (32'(py_ff) < 32'(FB_HEIGHT));
   assign div_start  = (state_ff == ST_SUM);
   assign pass_ok    = (depth_ff < ram_rdata);

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = idx_ff;
      ram_wdata = depth_ff;
      if (state_ff == ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = DMAX;
      end else if (state_ff == ST_TEST && pass_ok) begin
         ram_we = 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(NPIX - 1)) state_in = ST_IDLE;
         end
         ST_IDLE:  if (accept) state_in = ST_AREA;
         ST_AREA:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_PROD;
         // The flags were registered at the end of the previous step.
         ST_PROD:  state_in = (!culled_ff && covered_ff) ? ST_SUM : ST_OUT;
         ST_SUM:   state_in = ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_READ;
         ST_READ:  state_in = ST_TEST;
         ST_TEST:  state_in = ST_OUT;
         ST_OUT:   if (rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         face_cull_ff <= tcdt_pkg::CULL_NONE;
         front_ccw_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_we && csr_index == tcdt_pkg::REG_FACE_CULL) face_cull_ff <= csr_wdata;
         if (csr_we && csr_index == tcdt_pkg::REG_FRONT_IS_CCW) front_ccw_ff <= csr_wdata[0];
      end
   end

   // Datapath: one register stage per step of the sequence.
   always_ff @(posedge clock) begin
      logic ccw, front, cul, pos, ok;
      if (accept) begin
         ax_ff <= req_tdata[11:0];    ay_ff <= req_tdata[23:12];
         az_ff <= req_tdata[47:24];   bx_ff <= req_tdata[59:48];
         by_ff <= req_tdata[71:60];   bz_ff <= req_tdata[95:72];
         cx_ff <= req_tdata[107:96];  cy_ff <= req_tdata[119:108];
         cz_ff <= req_tdata[143:120]; px_ff <= req_tdata[151:144];
         py_ff <= req_tdata[159:152];
         written_ff <= 1'b0;
         depth_ff   <= '0;
      end
      if (state_ff == ST_AREA) begin
         t_ff  <= area2(SW'(ax_ff), SW'(ay_ff), SW'(bx_ff), SW'(by_ff),
                        SW'(cx_ff), SW'(cy_ff));
         s0_ff <= area2(SW'({1'b0, px_ff}), SW'({1'b0, py_ff}), SW'(bx_ff), SW'(by_ff),
                        SW'(cx_ff), SW'(cy_ff));
         s1_ff <= area2(SW'({1'b0, px_ff}), SW'({1'b0, py_ff}), SW'(cx_ff), SW'(cy_ff),
                        SW'(ax_ff), SW'(ay_ff));
         s2_ff <= area2(SW'({1'b0, px_ff}), SW'({1'b0, py_ff}), SW'(ax_ff), SW'(ay_ff),
                        SW'(bx_ff), SW'(by_ff));
         idx_ff <= AW'(32'(py_ff) * 32'(FB_WIDTH) + 32'(px_ff));
      end
      if (state_ff == ST_MUL) begin
         ccw   = (t_ff > 0);
         front = front_ccw_ff ? ccw : !ccw;
         cul   = (face_cull_ff == tcdt_pkg::CULL_BACK && !front) ||
                 (face_cull_ff == tcdt_pkg::CULL_FRONT && front);
         pos   = ccw;
         ok    = pos ? (s0_ff >= 0 && s1_ff >= 0 && s2_ff >= 0)
                     : (s0_ff <= 0 && s1_ff <= 0 && s2_ff <= 0);
         culled_ff  <= cul;
         covered_ff <= !cul && (t_ff != 0) && in_fb && ok;
         m0_ff <= mag(s0_ff);
         m1_ff <= mag(s1_ff);
         m2_ff <= mag(s2_ff);
         mt_ff <= mag(t_ff);
      end
      if (div_done) begin
         if (tcdt_pkg::QUO_W > DEPTH_BITS &&
             (quo >> DEPTH_BITS) != '0) depth_ff <= DMAX;
         else depth_ff <= DEPTH_BITS'(quo);
      end
      if (state_ff == ST_TEST) written_ff <= pass_ok;
   end

   // Products registered before the sum, from the registered magnitudes. They
   // settle at the end of the product step and are summed into the divider.
   always_ff @(posedge clock) begin
      p0_ff <= tcdt_pkg::NUM_W'(m0_ff) * tcdt_pkg::NUM_W'(az_ff);
      p1_ff <= tcdt_pkg::NUM_W'(m1_ff) * tcdt_pkg::NUM_W'(bz_ff);
      p2_ff <= tcdt_pkg::NUM_W'(m2_ff) * tcdt_pkg::NUM_W'(cz_ff);
   end

   tcdt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (p0_ff + p1_ff + p2_ff),
      .den   (mt_ff),
      .done  (div_done),
      .quo   (quo)
   );

   tcdt_ram #(.WIDTH(DEPTH_BITS), .DEPTH(NPIX)) u_depth (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_tdata = 48'({24'(depth_ff), written_ff, covered_ff && !culled_ff,
                           culled_ff, py_ff, px_ff});

   `ASSERT_IMPL(a_no_accept_clear, clock, reset, state_ff == ST_CLEAR, !req_tready,
                "input accepted during clearing pass")
   `ASSERT_IMPL(a_write_covered, clock, reset, ram_we && state_ff != ST_CLEAR,
                covered_ff && !culled_ff, "depth write for uncovered pixel")
   `ASSERT_IMPL(a_culled_clean, clock, reset, rsp_tvalid && culled_ff,
                !written_ff && depth_ff == '0, "culled result carries depth")
   `ASSERT_NEXT(a_out_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid,
                "result dropped while stalled")
endmodule

[tb/sv/tcdt_scoreboard.sv]
// Scoreboard for the triangle coverage and depth test block: it watches both
// streams and the register port, predicts every response word and compares it.
// Depends on tcdt_pkg for the cull mode codes and register indexes.
`timescale 1ns / 1ps
module tcdt_scoreboard (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [167:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [47:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [1:0]   csr_wdata,
   output int           fails,
   output int           pending
);
   typedef struct packed {
      logic [23:0] frag_depth;
      logic        written;
      logic        covered;
      logic        culled;
      logic [7:0]  out_y;
      logic [7:0]  out_x;
   } frag_result_type;

   logic [23:0]     zbuf [0:65535];
   logic [1:0]      face_cull_q;
   logic            front_ccw_q;
   frag_result_type frag_queue [$];

   function automatic longint area2(longint x0, longint y0, longint x1, longint y1,
                                    longint x2, longint y2);
      return (y1 - y0) * (x1 + x0) + (y2 - y1) * (x2 + x1) + (y0 - y2) * (x0 + x2);
   endfunction

   function automatic longint absval(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Works out the response to one word and updates the shadow depth buffer.
   function automatic frag_result_type shade_fragment(logic [167:0] w);
      frag_result_type r;
      longint ax, ay, bx, by, cx, cy, px, py, t, s0, s1, s2, num, dep;
      logic [23:0] az, bz, cz;
      logic ccw, front, pos;
      int idx;
      ax = $signed(w[11:0]);    ay = $signed(w[23:12]);   az = w[47:24];
      bx = $signed(w[59:48]);   by = $signed(w[71:60]);   bz = w[95:72];
      cx = $signed(w[107:96]);  cy = $signed(w[119:108]); cz = w[143:120];
      px = w[151:144];          py = w[159:152];
      r = '0;
      r.out_x = w[151:144];
      r.out_y = w[159:152];
      t = area2(ax, ay, bx, by, cx, cy);
      ccw = (t > 0);
      front = front_ccw_q ? ccw : !ccw;
      r.culled = (face_cull_q == tcdt_pkg::CULL_BACK && !front) ||
                 (face_cull_q == tcdt_pkg::CULL_FRONT && front);
      if (!r.culled && t != 0) begin
         s0 = area2(px, py, bx, by, cx, cy);
         s1 = area2(px, py, cx, cy, ax, ay);
         s2 = area2(px, py, ax, ay, bx, by);
         pos = (t > 0);
         if (pos ? (s0 >= 0 && s1 >= 0 && s2 >= 0) : (s0 <= 0 && s1 <= 0 && s2 <= 0)) begin
            num = absval(s0) * longint'(az) + absval(s1) * longint'(bz)
                + absval(s2) * longint'(cz);
            dep = num / absval(t);
            if (dep > 64'hFFFFFF) dep = 64'hFFFFFF;
            r.covered = 1'b1;
            r.frag_depth = dep[23:0];
            idx = int'(py) * 256 + int'(px);
            if (dep[23:0] < zbuf[idx]) begin
               zbuf[idx] = dep[23:0];
               r.written = 1'b1;
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      frag_result_type exp_r, got_r;
      if (reset) begin
         for (int i = 0; i < 65536; i++) zbuf[i] = 24'hFFFFFF;
         face_cull_q = tcdt_pkg::CULL_NONE;
         front_ccw_q = 1'b1;
         frag_queue.delete();
         fails = 0;
         pending = 0;
      end else begin
         if (csr_we) begin
            if (csr_index == tcdt_pkg::REG_FACE_CULL) face_cull_q = csr_wdata;
            else if (csr_index == tcdt_pkg::REG_FRONT_IS_CCW) front_ccw_q = csr_wdata[0];
         end
         if (req_tvalid && req_tready) frag_queue.push_back(shade_fragment(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got_r = rsp_tdata[42:0];
            if (frag_queue.size() == 0) begin
               $error("response word with no prediction pending: %h", rsp_tdata);
               fails++;
            end else begin
               exp_r = frag_queue.pop_front();
               if (got_r.out_x !== exp_r.out_x) begin
                  $error("out_x expected %0d got %0d", exp_r.out_x, got_r.out_x); fails++;
               end
               if (got_r.out_y !== exp_r.out_y) begin
                  $error("out_y expected %0d got %0d", exp_r.out_y, got_r.out_y); fails++;
               end
               if (got_r.culled !== exp_r.culled) begin
                  $error("culled expected %0b got %0b", exp_r.culled, got_r.culled); fails++;
               end
               if (got_r.covered !== exp_r.covered) begin
                  $error("covered expected %0b got %0b", exp_r.covered, got_r.covered);
                  fails++;
               end
               if (got_r.written !== exp_r.written) begin
                  $error("written expected %0b got %0b", exp_r.written, got_r.written);
                  fails++;
               end
               if (got_r.frag_depth !== exp_r.frag_depth) begin
                  $error("frag_depth expected %h got %h", exp_r.frag_depth, got_r.frag_depth);
                  fails++;
               end
            end
         end
         pending = frag_queue.size();
      end
   end
endmodule

[tb/sv/triangle_coverage_depth_test_tb.sv]
// Top of the testbench for the triangle coverage and depth test block.
// Drives stimulus and gives the verdict; depends on tcdt_pkg and tcdt_scoreboard.
`timescale 1ns / 1ps
module triangle_coverage_depth_test_tb;
   // Code three is not a named mode; the block treats it as no culling.
   localparam logic [1:0] CULL_SPARE = 2'd3;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [167:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [47:0]  rsp_tdata;
   logic         csr_we = 1'b0;
   logic         csr_index = 1'b0;
   logic [1:0]   csr_wdata = '0;
   int           fails;
   int           pending;

   // When quiet is set neither side idles; long_hold asks the receiver for one
   // long stall so that the block backs up and drops req_tready.
   bit quiet = 0;
   bit long_hold = 0;
   int words_sent = 0;

   triangle_coverage_depth_test i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   tcdt_scoreboard i_scoreboard (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fails(fails), .pending(pending)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Generous limit that covers the clearing pass after reset and every word with
   // its random idling on both streams.
   initial begin
      #(3_000_000 * 20);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic int idle_draw();
      return quiet ? 0 : $urandom_range(0, 16);
   endfunction

   // Packs one request word, fields from bit 0 up as the port comment lists.
   function automatic logic [167:0] tri_word(int ax, int ay, int az, int bx, int by, int bz,
                                             int cx, int cy, int cz, int px, int py);
      logic [11:0] q_ax, q_ay, q_bx, q_by, q_cx, q_cy;
      logic [23:0] q_az, q_bz, q_cz;
      logic [7:0]  q_px, q_py;
      q_ax = 12'(ax); q_ay = 12'(ay); q_bx = 12'(bx); q_by = 12'(by);
      q_cx = 12'(cx); q_cy = 12'(cy);
      q_az = 24'(az); q_bz = 24'(bz); q_cz = 24'(cz);
      q_px = 8'(px);  q_py = 8'(py);
      return {8'h00, q_py, q_px, q_cz, q_cy, q_cx, q_bz, q_by, q_bx, q_az, q_ay, q_ax};
   endfunction

   // Offers one word after a random gap and holds it until accepted. The task is
   // entered and left at a falling edge; valid stays high if the next gap is zero.
   task automatic send_word(logic [167:0] w);
      int gap;
      gap = idle_draw();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= w;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      @(negedge clock);
   endtask

   // Registers change only while nothing is in flight.
   task automatic write_reg(logic idx, logic [1:0] val);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (70) @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Mostly small triangles around the pixel, so that coverage and the depth
   // test both go either way; some words use every bit of every field.
   function automatic logic [167:0] random_word();
      int px, py, span;
      if ($urandom_range(0, 9) < 2)
         return tri_word($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom, $urandom, $urandom, $urandom);
      // A small pixel window gives repeated hits on the same depth entries.
      if ($urandom_range(0, 1)) begin
         px = $urandom_range(0, 7); py = $urandom_range(0, 7);
      end else begin
         px = $urandom_range(0, 255); py = $urandom_range(0, 255);
      end
      span = $urandom_range(0, 3) == 0 ? 400 : 24;
      return tri_word(px + $urandom_range(0, 2 * span) - span,
                      py + $urandom_range(0, 2 * span) - span, $urandom,
                      px + $urandom_range(0, 2 * span) - span,
                      py + $urandom_range(0, 2 * span) - span, $urandom,
                      px + $urandom_range(0, 2 * span) - span,
                      py + $urandom_range(0, 2 * span) - span, $urandom, px, py);
   endfunction

   // Receiver: a random stall before each word, and one long stall on request.
   initial begin
      int stall;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_tready <= 1'b0;
            repeat (400) @(negedge clock);
            long_hold = 0;
         end
         stall = idle_draw();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin
      logic [1:0] modes [8] = '{tcdt_pkg::CULL_NONE, tcdt_pkg::CULL_BACK,
                                tcdt_pkg::CULL_FRONT, CULL_SPARE,
                                tcdt_pkg::CULL_BACK, tcdt_pkg::CULL_FRONT,
                                tcdt_pkg::CULL_NONE, CULL_SPARE};
      logic       ccws  [8] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};
      int waited;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed words under the reset settings: a huge triangle with extreme
      // depths, repeated pixels (equal depth must not write), edges, vertices,
      // a zero-area triangle, clockwise winding and extreme coordinates.
      send_word(tri_word(-2048, -2048, 0, 2047, -2048, 0, 0, 2047, 0, 0, 0));
      send_word(tri_word(-2048, -2048, 0, 2047, -2048, 0, 0, 2047, 0, 0, 0));
      send_word(tri_word(-2048, -2048, 24'hFFFFFF, 2047, -2048, 24'hFFFFFF,
                         -2048, 2047, 24'hFFFFFF, 255, 255));
      send_word(tri_word(0, 0, 100, 255, 0, 200, 0, 255, 300, 255, 255));
      send_word(tri_word(0, 0, 100, 255, 0, 200, 0, 255, 300, 128, 127));
      send_word(tri_word(0, 0, 100, 255, 0, 200, 0, 255, 300, 128, 128));
      send_word(tri_word(10, 10, 500, 20, 10, 600, 10, 20, 700, 10, 10));
      send_word(tri_word(10, 10, 400, 20, 10, 600, 10, 20, 700, 10, 10));
      send_word(tri_word(10, 10, 5, 20, 10, 6, 10, 20, 7, 15, 10));
      send_word(tri_word(0, 0, 9, 50, 50, 9, 100, 100, 9, 25, 25));
      send_word(tri_word(5, 5, 9, 5, 5, 9, 5, 5, 9, 5, 5));
      send_word(tri_word(0, 0, 1000, 0, 60, 2000, 60, 0, 3000, 10, 10));
      send_word(tri_word(0, 0, 1000, 0, 60, 2000, 60, 0, 3000, 70, 70));
      send_word(tri_word(2047, 2047, 24'hFFFFFF, -2048, 2047, 0, 2047, -2048, 77, 200, 30));
      send_word(tri_word(-1, -1, 24'h800000, 300, -1, 24'h7FFFFF, -1, 300, 1, 0, 255));
      send_word(tri_word(-2048, 2047, 0, -2048, -2048, 24'hFFFFFF, 2047, 0, 3, 255, 0));

      // Phases over the cull settings, extremes among them; the first one runs
      // without idling and the third one asks for the long receiver stall.
      for (int ph = 0; ph < 8; ph++) begin
         write_reg(tcdt_pkg::REG_FACE_CULL, modes[ph]);
         write_reg(tcdt_pkg::REG_FRONT_IS_CCW, {1'b0, ccws[ph]});
         quiet = (ph == 0);
         if (ph == 2) long_hold = 1;
         for (int n = 0; n < 160; n++) send_word(random_word());
         // The sender pauses here until every result of the phase is back.
         req_tvalid <= 1'b0;
         while (pending != 0) @(negedge clock);
      end

      req_tvalid <= 1'b0;
      waited = 0;
      while (pending != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (80) @(negedge clock);
      $display("Ran %0d triangle-pixel words through 8 cull and winding settings,",
               words_sent);
      $display("with random idling on both streams and one long response stall.");
      if (fails == 0 && pending == 0) begin
         $display("Testbench completed without errors");
      end else begin
         if (pending != 0) $error("%0d predicted responses never arrived", pending);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
